/* rtl/rau_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the rational unit.
package rau_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int WIDE         = 2 * DATA_WIDTH;
    localparam int MODE_W       = 3;
    localparam int EXP_W        = 4;
    localparam int ST_W         = 2;
    localparam int MAX_EXPONENT = 15;
    localparam int CNT_W        = $clog2(WIDE);

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEG = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POW = 3'd5;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
    localparam logic [ST_W-1:0] ST_ZDEN = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_T,
        CMD_MUL_N,
        CMD_ADD,
        CMD_MUL_D,
        CMD_NEG,
        CMD_ONE,
        CMD_ZERO,
        CMD_COPY_A,
        CMD_GCD_INIT,
        CMD_GCD_STEP,
        CMD_DIV_INIT_N,
        CMD_DIV_STEP,
        CMD_DIV_INIT_D,
        CMD_DIV_END_D,
        CMD_POW_INIT_N,
        CMD_POW_STEP,
        CMD_POW_END_N,
        CMD_POW_END_D,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              p_zero;
        logic              ad_zero;
        logic              d_zero;
        logic              gcd_done;
        logic              div_last;
        logic              pow_done;
    } t_dp_stat;

endpackage

/* rtl/rational_arith_unit_core.sv */
// Top level of the rational arithmetic unit: sequencer plus datapath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid/o_in_ready, i_mode..i_exponent | into block
//  out     | o_out_valid/i_out_ready, o_res_*, o_status | out of block
//
// One transaction is worked at a time. Negate, power zero and unused modes set the
// result directly and finish; add/sub/mul/div run a one-step-per-cycle binary
// gcd on 64-bit magnitudes (skipped when the denominator product is zero) and then
// two restoring divisions; power reduces the 32-bit operands the same way and then
// raises numerator and denominator to the exponent by repeated multiplication.
// Reset (i_rst_n low, synchronous) clears the sequencer and the output valid.
// A new transaction is taken while a finished result still waits on the output;
// the next result holds in its final state until the output register frees up.
module rational_arith_unit_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [rau_pkg::MODE_W-1:0]            i_mode,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] i_a_num,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] i_a_den,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] i_b_num,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] i_b_den,
    input  logic [rau_pkg::EXP_W-1:0]             i_exponent,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [rau_pkg::DATA_WIDTH-1:0] o_res_num,
    output logic signed [rau_pkg::DATA_WIDTH-1:0] o_res_den,
    output logic [rau_pkg::ST_W-1:0]              o_status
);

    rau_pkg::t_cmd     cmd;
    rau_pkg::t_dp_stat stat;

    // sequencer: issues one datapath command per cycle
    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: operands, multiplier, gcd, divider, result register
    rau_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_mode     (i_mode),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .i_exponent (i_exponent),
        .o_stat     (stat),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_status   (o_status)
    );

endmodule

/* rtl/rau_ctrl.sv */
// Sequencer for the rational unit: steps the datapath and owns the handshakes.
module rau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rau_pkg::t_dp_stat i_stat,
    output rau_pkg::t_cmd     o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_PREP  = 16'h0002,
        S_MULN  = 16'h0004,
        S_ADD   = 16'h0008,
        S_MULD  = 16'h0010,
        S_CHK   = 16'h0020,
        S_GINIT = 16'h0040,
        S_GCD   = 16'h0080,
        S_DIVN  = 16'h0100,
        S_DIVNE = 16'h0200,
        S_DIVD  = 16'h0400,
        S_DIVDE = 16'h0800,
        S_PINIT = 16'h1000,
        S_POWN  = 16'h2000,
        S_POWD  = 16'h4000,
        S_FIN   = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   addsub;

    assign addsub      = (i_stat.mode == rau_pkg::MODE_ADD) || (i_stat.mode == rau_pkg::MODE_SUB);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = rau_pkg::CMD_NONE;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = rau_pkg::CMD_LOAD;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (addsub) begin
                    o_cmd   = rau_pkg::CMD_MUL_T;
                    n_state = S_MULN;
                end else if ((i_stat.mode == rau_pkg::MODE_MUL) ||
                             (i_stat.mode == rau_pkg::MODE_DIV)) begin
                    o_cmd   = rau_pkg::CMD_MUL_N;
                    n_state = S_MULD;
                end else if (i_stat.mode == rau_pkg::MODE_NEG) begin
                    o_cmd   = rau_pkg::CMD_NEG;
                    n_state = S_FIN;
                end else if (i_stat.mode == rau_pkg::MODE_POW) begin
                    if (i_stat.p_zero) begin
                        o_cmd   = rau_pkg::CMD_ONE;
                        n_state = S_FIN;
                    end else if (i_stat.ad_zero) begin
                        o_cmd   = rau_pkg::CMD_ZERO;
                        n_state = S_FIN;
                    end else begin
                        o_cmd   = rau_pkg::CMD_COPY_A;
                        n_state = S_GINIT;
                    end
                end else begin
                    o_cmd   = rau_pkg::CMD_ZERO;
                    n_state = S_FIN;
                end
            end
            S_MULN: begin
                o_cmd   = rau_pkg::CMD_MUL_N;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd   = rau_pkg::CMD_ADD;
                n_state = S_MULD;
            end
            S_MULD: begin
                o_cmd   = rau_pkg::CMD_MUL_D;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = i_stat.d_zero ? S_FIN : S_GINIT;
            end
            S_GINIT: begin
                o_cmd   = rau_pkg::CMD_GCD_INIT;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    o_cmd   = rau_pkg::CMD_DIV_INIT_N;
                    n_state = S_DIVN;
                end else begin
                    o_cmd = rau_pkg::CMD_GCD_STEP;
                end
            end
            S_DIVN: begin
                o_cmd = rau_pkg::CMD_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_DIVNE;
                end
            end
            S_DIVNE: begin
                o_cmd   = rau_pkg::CMD_DIV_INIT_D;
                n_state = S_DIVD;
            end
            S_DIVD: begin
                o_cmd = rau_pkg::CMD_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_DIVDE;
                end
            end
            S_DIVDE: begin
                o_cmd   = rau_pkg::CMD_DIV_END_D;
                n_state = (i_stat.mode == rau_pkg::MODE_POW) ? S_PINIT : S_FIN;
            end
            S_PINIT: begin
                o_cmd   = rau_pkg::CMD_POW_INIT_N;
                n_state = S_POWN;
            end
            S_POWN: begin
                if (i_stat.pow_done) begin
                    o_cmd   = rau_pkg::CMD_POW_END_N;
                    n_state = S_POWD;
                end else begin
                    o_cmd = rau_pkg::CMD_POW_STEP;
                end
            end
            S_POWD: begin
                if (i_stat.pow_done) begin
                    o_cmd   = rau_pkg::CMD_POW_END_D;
                    n_state = S_FIN;
                end else begin
                    o_cmd = rau_pkg::CMD_POW_STEP;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd       = rau_pkg::CMD_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/rau_dp.sv */
// Datapath of the rational unit: operand registers, shared multiplier, gcd, divider, output.
module rau_dp (
    input  logic                                i_clk,
    input  rau_pkg::t_cmd                       i_cmd,
    input  logic [rau_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] i_a_num,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] i_a_den,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] i_b_num,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] i_b_den,
    input  logic [rau_pkg::EXP_W-1:0]           i_exponent,
    output rau_pkg::t_dp_stat                   o_stat,
    output logic signed [rau_pkg::DATA_WIDTH-1:0] o_res_num,
    output logic signed [rau_pkg::DATA_WIDTH-1:0] o_res_den,
    output logic [rau_pkg::ST_W-1:0]            o_status
);

    localparam int DW = rau_pkg::DATA_WIDTH;
    localparam int WW = rau_pkg::WIDE;
    localparam int CW = rau_pkg::CNT_W;
    localparam logic [WW-1:0] LIM = WW'(1) << (DW - 1);
    localparam logic [WW-1:0] CAP = LIM + WW'(1);

    logic [rau_pkg::MODE_W-1:0] r_mode;
    logic [rau_pkg::EXP_W-1:0]  r_p;
    logic                       r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [DW-1:0]              r_an, r_ad, r_bn, r_bd;
    logic                       r_n_neg, r_d_neg, r_t_neg;
    logic [WW-1:0]              r_n, r_d, r_t;
    logic [WW-1:0]              r_gx, r_gy, r_g, r_quo, r_acc;
    logic [CW-1:0]              r_gk, r_dcnt;
    logic [WW:0]                r_rem;
    logic [rau_pkg::EXP_W-1:0]  r_pc;
    logic signed [DW-1:0]       r_res_num, r_res_den;
    logic [rau_pkg::ST_W-1:0]   r_status;

    logic [DW-1:0] mul_a, mul_b;
    logic          mul_sx, mul_sy;
    logic [WW-1:0] prod;
    logic          prod_neg;
    logic [WW-1:0] sum_mag;
    logic          sum_neg;
    logic [WW-1:0] gval;
    logic [WW:0]   rem_sh, rem_sub;
    logic [WW-1:0] acc_next;
    logic          n_ok, d_ok;
    logic          addsub;

    function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + DW'(1)) : v;
    endfunction

    assign addsub = (r_mode == rau_pkg::MODE_ADD) || (r_mode == rau_pkg::MODE_SUB);

    // shared multiplier operand select
    always_comb begin
        mul_a  = r_an;
        mul_b  = r_bd;
        mul_sx = r_an_s;
        mul_sy = r_bd_s;
        case (i_cmd)
            rau_pkg::CMD_MUL_N: begin
                if (addsub) begin
                    mul_a  = r_bn;
                    mul_b  = r_ad;
                    mul_sx = r_bn_s ^ (r_mode == rau_pkg::MODE_SUB);
                    mul_sy = r_ad_s;
                end else if (r_mode == rau_pkg::MODE_MUL) begin
                    mul_b  = r_bn;
                    mul_sy = r_bn_s;
                end
            end
            rau_pkg::CMD_MUL_D: begin
                mul_a  = r_ad;
                mul_sx = r_ad_s;
                if (r_mode == rau_pkg::MODE_DIV) begin
                    mul_b  = r_bn;
                    mul_sy = r_bn_s;
                end
            end
            rau_pkg::CMD_POW_STEP: begin
                mul_a  = r_acc[DW-1:0];
                mul_b  = r_t[DW-1:0];
                mul_sx = 1'b0;
                mul_sy = 1'b0;
            end
            default: begin
            end
        endcase
        prod     = WW'(mul_a) * WW'(mul_b);
        prod_neg = (prod != '0) && (mul_sx ^ mul_sy);
        acc_next = (prod > CAP) ? CAP : prod;
    end

    // sign-magnitude add of t and n
    always_comb begin
        if (r_t_neg == r_n_neg) begin
            sum_mag = r_t + r_n;
            sum_neg = r_t_neg;
        end else if (r_t >= r_n) begin
            sum_mag = r_t - r_n;
            sum_neg = r_t_neg;
        end else begin
            sum_mag = r_n - r_t;
            sum_neg = r_n_neg;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    assign gval    = ((r_gx == '0) ? r_gy : r_gx) << r_gk;
    assign rem_sh  = {r_rem[WW-1:0], r_quo[WW-1]};
    assign rem_sub = rem_sh - {1'b0, r_g};

    assign n_ok = r_n_neg ? (r_n <= LIM) : (r_n < LIM);
    assign d_ok = r_d_neg ? (r_d <= LIM) : (r_d < LIM);

    assign o_stat.mode     = r_mode;
    assign o_stat.p_zero   = (r_p == '0);
    assign o_stat.ad_zero  = (r_ad == '0);
    assign o_stat.d_zero   = (r_d == '0);
    assign o_stat.gcd_done = (r_gx == '0) || (r_gy == '0) || (r_gx == r_gy);
    assign o_stat.div_last = (r_dcnt == CW'(WW - 1));
    assign o_stat.pow_done = (r_pc == '0);

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            rau_pkg::CMD_LOAD: begin
                r_mode <= i_mode;
                r_p    <= (i_exponent > rau_pkg::MAX_EXPONENT)
                          ? rau_pkg::EXP_W'(rau_pkg::MAX_EXPONENT) : i_exponent;
                r_an_s <= i_a_num[DW-1];
                r_ad_s <= i_a_den[DW-1];
                r_bn_s <= i_b_num[DW-1];
                r_bd_s <= i_b_den[DW-1];
                r_an   <= mag_of(i_a_num);
                r_ad   <= mag_of(i_a_den);
                r_bn   <= mag_of(i_b_num);
                r_bd   <= mag_of(i_b_den);
            end
            rau_pkg::CMD_MUL_T: begin
                r_t     <= prod;
                r_t_neg <= prod_neg;
            end
            rau_pkg::CMD_MUL_N: begin
                r_n     <= prod;
                r_n_neg <= prod_neg;
            end
            rau_pkg::CMD_ADD: begin
                r_n     <= sum_mag;
                r_n_neg <= sum_neg;
            end
            rau_pkg::CMD_MUL_D: begin
                r_d     <= prod;
                r_d_neg <= prod_neg;
            end
            rau_pkg::CMD_NEG: begin
                r_n     <= WW'(r_an);
                r_n_neg <= (r_an != '0) && !r_an_s;
                r_d     <= WW'(r_ad);
                r_d_neg <= r_ad_s;
            end
            rau_pkg::CMD_ONE: begin
                r_n     <= WW'(1);
                r_n_neg <= 1'b0;
                r_d     <= WW'(1);
                r_d_neg <= 1'b0;
            end
            rau_pkg::CMD_ZERO: begin
                r_n     <= '0;
                r_n_neg <= 1'b0;
                r_d     <= '0;
                r_d_neg <= 1'b0;
            end
            rau_pkg::CMD_COPY_A: begin
                r_n     <= WW'(r_an);
                r_n_neg <= r_an_s;
                r_d     <= WW'(r_ad);
                r_d_neg <= r_ad_s;
            end
            rau_pkg::CMD_GCD_INIT: begin
                r_gx <= r_n;
                r_gy <= r_d;
                r_gk <= '0;
            end
            rau_pkg::CMD_GCD_STEP: begin
                if (!r_gx[0] && !r_gy[0]) begin
                    r_gx <= r_gx >> 1;
                    r_gy <= r_gy >> 1;
                    r_gk <= r_gk + CW'(1);
                end else if (!r_gx[0]) begin
                    r_gx <= r_gx >> 1;
                end else if (!r_gy[0]) begin
                    r_gy <= r_gy >> 1;
                end else if (r_gx > r_gy) begin
                    r_gx <= r_gx - r_gy;
                end else begin
                    r_gy <= r_gy - r_gx;
                end
            end
            rau_pkg::CMD_DIV_INIT_N: begin
                r_g    <= gval;
                r_quo  <= r_n;
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            rau_pkg::CMD_DIV_STEP: begin
                if (!rem_sub[WW]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[WW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[WW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + CW'(1);
            end
            rau_pkg::CMD_DIV_INIT_D: begin
                r_n     <= r_quo;
                r_n_neg <= r_n_neg && (r_quo != '0);
                r_quo   <= r_d;
                r_rem   <= '0;
                r_dcnt  <= '0;
            end
            rau_pkg::CMD_DIV_END_D: begin
                r_d <= r_quo;
            end
            rau_pkg::CMD_POW_INIT_N: begin
                r_t   <= r_n;
                r_acc <= WW'(1);
                r_pc  <= r_p;
            end
            rau_pkg::CMD_POW_STEP: begin
                r_acc <= acc_next;
                r_pc  <= r_pc - rau_pkg::EXP_W'(1);
            end
            rau_pkg::CMD_POW_END_N: begin
                r_n     <= r_acc;
                r_n_neg <= r_n_neg && r_p[0] && (r_acc != '0);
                r_t     <= r_d;
                r_acc   <= WW'(1);
                r_pc    <= r_p;
            end
            rau_pkg::CMD_POW_END_D: begin
                r_d     <= r_acc;
                r_d_neg <= r_d_neg && r_p[0];
            end
            rau_pkg::CMD_FINISH: begin
                if (r_mode > rau_pkg::MODE_POW) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_status  <= rau_pkg::ST_OK;
                end else if (r_d == '0) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_status  <= rau_pkg::ST_ZDEN;
                end else if (!n_ok || !d_ok) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_status  <= rau_pkg::ST_OVF;
                end else begin
                    r_res_num <= r_n_neg ? -r_n[DW-1:0] : r_n[DW-1:0];
                    r_res_den <= r_d_neg ? -r_d[DW-1:0] : r_d[DW-1:0];
                    r_status  <= rau_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
